// File: sv/arll_pkg.sv
package arll_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [2:0] {
      OP_ADD_FIRST = 3'd0,
      OP_ADD_LAST  = 3'd1,
      OP_ADD_AFTER = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_AFTER = 3'd5,
      OP_CLEAR     = 3'd6,
      OP_FIND      = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADSLOT  = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_INS_A,
      S_INS_B,
      S_ADD_FRONT,
      S_DEL_FRONT,
      S_DA_CHECK,
      S_RM_B,
      S_FIND,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] key;
      logic [3:0]  prev_slot;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [4:0] count;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [3:0]  prev_slot;
   } cmd_type;

endpackage

// File: sv/array_linked_list_engine_top.sv
// singly linked list kept in a slot array of CAPACITY entries: each request
// adds (first, last, after a slot), deletes (first, last, after a slot), clears
// or finds by key, and gives exactly one result with status, slot and count.
// adds take the lowest free slot. add last, delete last and find follow the
// links one per cycle through the key and link memories. requests queue two
// deep in front of the engine and one result waits in the output register, so
// both sides may stall independently
module array_linked_list_engine_top #(
   parameter int CAPACITY = arll_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = arll_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_push,
   output logic              req_full,
   input  arll_pkg::req_type req_data,
   // result side
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output arll_pkg::rsp_type rsp_data
);

   logic              cmd_valid, cmd_take;
   arll_pkg::cmd_type cmd;
   logic              res_valid, res_take;
   arll_pkg::rsp_type res;
   logic              out_valid_ff, out_valid_in;
   arll_pkg::rsp_type out_ff;

   // request queue and op decode
   arll_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // list engine: slot state, link walk and updates
   arll_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // output register, refilled in the cycle it is popped
   assign res_take  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_take) out_valid_in = res_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res_take && res_valid) begin
         out_ff <= res;
      end
   end

endmodule

// File: sv/arll_ram.sv
module arll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/arll_front.sv
module arll_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  arll_pkg::req_type req_data,
   output logic              cmd_valid,
   output arll_pkg::cmd_type cmd,
   input  logic              cmd_take
);

   localparam int PW = (arll_pkg::QUEUE_DEPTH > 1) ? $clog2(arll_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(arll_pkg::QUEUE_DEPTH + 1);

   arll_pkg::cmd_type q_ff [arll_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push_ok, pop_ok;
   arll_pkg::cmd_type classified;

   // request op decoded into the command code
   always_comb begin
      classified.op        = arll_pkg::op_type'(req_data.op);
      classified.key       = req_data.key;
      classified.prev_slot = req_data.prev_slot;
   end

   assign req_full  = (cnt_ff == CW'(arll_pkg::QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_ok) begin
         wr_in = (wr_ff == PW'(arll_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_in = (rd_ff == PW'(arll_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wr_ff] <= classified;
      end
   end

endmodule

// File: sv/arll_back.sv
module arll_back #(
   parameter int CAPACITY = arll_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = arll_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  arll_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              res_valid,
   output arll_pkg::rsp_type res,
   input  logic              res_take
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   arll_pkg::state_type  state_ff, state_in;
   arll_pkg::op_type     op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [3:0]           prev4_ff, prev4_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [CW-1:0]        entries_ff, entries_in;
   logic [CAPACITY-1:0]  used_ff, used_in, tail_ff, tail_in;
   logic [SW-1:0]        cur_ff, cur_in, prv_ff, prv_in, tgt_ff, tgt_in;
   logic [SW-1:0]        victim_ff, victim_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   arll_pkg::status_type status_ff, status_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SW-1:0]        free_ff, free_in;
   logic                 any_free_ff, any_free_in;

   logic [SW-1:0]        rd_addr;
   logic [KEY_BITS-1:0]  key_q;
   logic [SW-1:0]        next_q;
   logic                 key_we, next_we;
   logic [SW-1:0]        key_waddr, next_waddr, next_wdata;

   logic                 full, empty, prev_ok, nx_in_range, nx_ok;
   logic                 walk_stop, del_last_front, find_hit, find_miss;
   logic [SW+3:0]        prev_ext;
   logic [SW-1:0]        prev_idx;
   logic [KEY_BITS+31:0] key_ext;
   logic [SW+3:0]        slot_ext;
   logic [CW+4:0]        count_ext;

   arll_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_ff),
      .raddr (rd_addr),
      .rdata (key_q)
   );

   arll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_links (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (rd_addr),
      .rdata (next_q)
   );

   // lowest free slot, registered from the used marks
   always_comb begin
      free_in     = '0;
      any_free_in = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_in     = SW'(i);
            any_free_in = 1'b1;
         end
      end
   end

   always_comb begin
      key_ext        = {{KEY_BITS{1'b0}}, cmd.key};
      prev_ext       = {{SW{1'b0}}, prev4_ff};
      prev_idx       = prev_ext[SW-1:0];
      full           = !any_free_ff || (entries_ff >= CW'(CAPACITY));
      empty          = (entries_ff == '0);
      prev_ok        = (prev_ext < (SW+4)'(CAPACITY)) && used_ff[prev_idx];
      nx_in_range    = ({1'b0, next_q} < (SW+1)'(CAPACITY));
      nx_ok          = nx_in_range && used_ff[next_q];
      walk_stop      = (cnt_ff == CW'(CAPACITY)) || tail_ff[cur_ff] || !nx_ok;
      del_last_front = (entries_ff == CW'(1)) || (cur_ff == head_ff);
      find_hit       = (key_q == key_ff);
      find_miss      = (cnt_ff == CW'(CAPACITY)) || !used_ff[cur_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arll_pkg::S_IDLE: begin
            if (cmd_valid) state_in = arll_pkg::S_DECODE;
         end
         arll_pkg::S_DECODE: begin
            unique case (op_ff)
               arll_pkg::OP_ADD_FIRST:
                  state_in = full ? arll_pkg::S_RESP : arll_pkg::S_ADD_FRONT;
               arll_pkg::OP_ADD_LAST:
                  state_in = full ? arll_pkg::S_RESP :
                             empty ? arll_pkg::S_ADD_FRONT : arll_pkg::S_WALK;
               arll_pkg::OP_ADD_AFTER:
                  state_in = (full || !prev_ok) ? arll_pkg::S_RESP : arll_pkg::S_INS_A;
               arll_pkg::OP_DEL_FIRST:
                  state_in = empty ? arll_pkg::S_RESP : arll_pkg::S_DEL_FRONT;
               arll_pkg::OP_DEL_LAST:
                  state_in = empty ? arll_pkg::S_RESP : arll_pkg::S_WALK;
               arll_pkg::OP_DEL_AFTER:
                  state_in = (!prev_ok || tail_ff[prev_idx]) ? arll_pkg::S_RESP :
                             arll_pkg::S_DA_CHECK;
               arll_pkg::OP_CLEAR:
                  state_in = arll_pkg::S_RESP;
               arll_pkg::OP_FIND:
                  state_in = empty ? arll_pkg::S_RESP : arll_pkg::S_FIND;
               default: state_in = arll_pkg::S_RESP;
            endcase
         end
         arll_pkg::S_WALK: begin
            if (walk_stop) begin
               if (op_ff == arll_pkg::OP_ADD_LAST) state_in = arll_pkg::S_INS_A;
               else if (del_last_front)            state_in = arll_pkg::S_DEL_FRONT;
               else                                state_in = arll_pkg::S_RM_B;
            end
         end
         arll_pkg::S_INS_A:     state_in = arll_pkg::S_INS_B;
         arll_pkg::S_INS_B:     state_in = arll_pkg::S_RESP;
         arll_pkg::S_ADD_FRONT: state_in = arll_pkg::S_RESP;
         arll_pkg::S_DEL_FRONT: state_in = arll_pkg::S_RESP;
         arll_pkg::S_DA_CHECK:  state_in = nx_ok ? arll_pkg::S_RM_B : arll_pkg::S_RESP;
         arll_pkg::S_RM_B:      state_in = arll_pkg::S_RESP;
         arll_pkg::S_FIND: begin
            priority if (find_miss)                              state_in = arll_pkg::S_RESP;
            else if (find_hit)                                   state_in = arll_pkg::S_RESP;
            else if (tail_ff[cur_ff] || !nx_in_range)            state_in = arll_pkg::S_RESP;
            else                                                 state_in = arll_pkg::S_FIND;
         end
         arll_pkg::S_RESP: begin
            if (res_take) state_in = arll_pkg::S_IDLE;
         end
         default: state_in = arll_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      prev4_in   = prev4_ff;
      head_in    = head_ff;
      entries_in = entries_ff;
      used_in    = used_ff;
      tail_in    = tail_ff;
      cur_in     = cur_ff;
      prv_in     = prv_ff;
      tgt_in     = tgt_ff;
      victim_in  = victim_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      rd_addr    = '0;
      key_we     = 1'b0;
      key_waddr  = free_ff;
      next_we    = 1'b0;
      next_waddr = free_ff;
      next_wdata = '0;
      cmd_take   = 1'b0;
      unique case (state_ff)
         arll_pkg::S_IDLE: begin
            cmd_take = 1'b1;
            op_in    = cmd.op;
            key_in   = key_ext[KEY_BITS-1:0];
            prev4_in = cmd.prev_slot;
         end
         arll_pkg::S_DECODE: begin
            cnt_in    = '0;
            cur_in    = head_ff;
            prv_in    = head_ff;
            tgt_in    = prev_idx;
            slot_in   = '0;
            status_in = arll_pkg::ST_OK;
            unique case (op_ff)
               arll_pkg::OP_ADD_FIRST: begin
                  if (full) status_in = arll_pkg::ST_FULL;
               end
               arll_pkg::OP_ADD_LAST: begin
                  if (full) status_in = arll_pkg::ST_FULL;
                  rd_addr = head_ff;
               end
               arll_pkg::OP_ADD_AFTER: begin
                  if (full)          status_in = arll_pkg::ST_FULL;
                  else if (!prev_ok) status_in = arll_pkg::ST_BADSLOT;
                  rd_addr = prev_idx;
               end
               arll_pkg::OP_DEL_FIRST, arll_pkg::OP_DEL_LAST, arll_pkg::OP_FIND: begin
                  if (empty) status_in = arll_pkg::ST_EMPTY;
                  rd_addr = head_ff;
               end
               arll_pkg::OP_DEL_AFTER: begin
                  if (!prev_ok || tail_ff[prev_idx]) status_in = arll_pkg::ST_BADSLOT;
                  rd_addr = prev_idx;
               end
               arll_pkg::OP_CLEAR: begin
                  used_in    = '0;
                  tail_in    = '0;
                  head_in    = '0;
                  entries_in = '0;
               end
               default: status_in = arll_pkg::ST_OK;
            endcase
         end
         arll_pkg::S_WALK: begin
            if (!walk_stop) begin
               prv_in  = cur_ff;
               cur_in  = next_q;
               cnt_in  = cnt_ff + 1'b1;
               rd_addr = next_q;
            end else if (op_ff == arll_pkg::OP_ADD_LAST) begin
               tgt_in  = cur_ff;
               rd_addr = cur_ff;
            end else if (del_last_front) begin
               rd_addr = head_ff;
            end else begin
               tgt_in    = prv_ff;
               victim_in = cur_ff;
               rd_addr   = cur_ff;
            end
         end
         arll_pkg::S_INS_A: begin
            victim_in         = free_ff;
            key_we            = 1'b1;
            next_we           = 1'b1;
            next_wdata        = next_q;
            used_in[free_ff]  = 1'b1;
            tail_in[free_ff]  = tail_ff[tgt_ff];
            tail_in[tgt_ff]   = 1'b0;
         end
         arll_pkg::S_INS_B: begin
            next_we    = 1'b1;
            next_waddr = tgt_ff;
            next_wdata = victim_ff;
            entries_in = entries_ff + 1'b1;
            status_in  = arll_pkg::ST_OK;
            slot_in    = victim_ff;
         end
         arll_pkg::S_ADD_FRONT: begin
            key_we           = 1'b1;
            next_we          = 1'b1;
            next_wdata       = empty ? '0 : head_ff;
            used_in[free_ff] = 1'b1;
            tail_in[free_ff] = empty;
            head_in          = free_ff;
            entries_in       = entries_ff + 1'b1;
            status_in        = arll_pkg::ST_OK;
            slot_in          = free_ff;
         end
         arll_pkg::S_DEL_FRONT: begin
            head_in = ((entries_ff <= CW'(1)) || tail_ff[head_ff]) ? '0 : next_q;
            used_in[head_ff] = 1'b0;
            tail_in[head_ff] = 1'b0;
            entries_in       = entries_ff - 1'b1;
            status_in        = arll_pkg::ST_OK;
            slot_in          = head_ff;
         end
         arll_pkg::S_DA_CHECK: begin
            if (nx_ok) begin
               victim_in = next_q;
               rd_addr   = next_q;
            end else begin
               status_in = arll_pkg::ST_BADSLOT;
            end
         end
         arll_pkg::S_RM_B: begin
            tail_in[tgt_ff]    = tail_ff[victim_ff];
            tail_in[victim_ff] = 1'b0;
            used_in[victim_ff] = 1'b0;
            next_we            = 1'b1;
            next_waddr         = tgt_ff;
            next_wdata         = next_q;
            entries_in         = entries_ff - 1'b1;
            status_in          = arll_pkg::ST_OK;
            slot_in            = victim_ff;
         end
         arll_pkg::S_FIND: begin
            priority if (find_miss) begin
               status_in = arll_pkg::ST_NOTFOUND;
            end else if (find_hit) begin
               status_in = arll_pkg::ST_OK;
               slot_in   = cur_ff;
            end else if (tail_ff[cur_ff] || !nx_in_range) begin
               status_in = arll_pkg::ST_NOTFOUND;
            end else begin
               cur_in  = next_q;
               cnt_in  = cnt_ff + 1'b1;
               rd_addr = next_q;
            end
         end
         arll_pkg::S_RESP: begin
            status_in = status_ff;
         end
         default: status_in = status_ff;
      endcase
   end

   always_comb begin
      slot_ext   = {4'b0, slot_ff};
      count_ext  = {5'b0, entries_ff};
      res_valid  = (state_ff == arll_pkg::S_RESP);
      res.status = status_ff;
      res.slot   = slot_ext[3:0];
      res.count  = count_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= arll_pkg::S_IDLE;
         head_ff     <= '0;
         entries_ff  <= '0;
         used_ff     <= '0;
         tail_ff     <= '0;
         free_ff     <= '0;
         any_free_ff <= 1'b1;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         entries_ff  <= entries_in;
         used_ff     <= used_in;
         tail_ff     <= tail_in;
         free_ff     <= free_in;
         any_free_ff <= any_free_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      prev4_ff  <= prev4_in;
      cur_ff    <= cur_in;
      prv_ff    <= prv_in;
      tgt_ff    <= tgt_in;
      victim_ff <= victim_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

endmodule
